>>> rtl/rbc_pkg.sv
// Shared types and constants for the ray/box closest hit block.
`default_nettype none
package rbc_pkg;
    localparam int COORD_W = 32;
    localparam int DIST_W = 31;
    localparam int IDX_W = 16;
    localparam int AXIS_W = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W = 32;
    localparam int MUL_W = 34;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST = 3'd6;

    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    localparam logic signed [COORD_W-1:0] T_MAX = 32'sh7fff_ffff;
    localparam logic signed [COORD_W-1:0] T_MIN = 32'sh8000_0000;
    localparam logic signed [COORD_W-1:0] DIR_X_RESET = 32'sd65536;
    localparam logic [DIST_W-1:0] MAX_DIST_RESET = 31'h7fff_ffff;

    typedef struct packed {
        logic [5:0][COORD_W-1:0] corner;
        logic [IDX_W-1:0]        index;
        logic                    enabled;
        logic                    last;
    } item_t;
endpackage
`default_nettype wire

>>> rtl/rbc_if.sv
// Box input and hit result channel interfaces.
`default_nettype none
interface rbc_box_if;
    logic valid;
    logic ready;
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_min_z;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic signed [31:0] box_max_z;
    logic box_enabled;
    logic last_box;
    modport source(output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
                   box_max_z, box_enabled, last_box, input ready);
    modport sink(input valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
                 box_max_z, box_enabled, last_box, output ready);
endinterface

interface rbc_hit_if;
    logic valid;
    logic ready;
    logic hit_found;
    logic [15:0] hit_index;
    logic [30:0] hit_distance;
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
    logic signed [31:0] hit_z;
    logic [1:0] normal_axis;
    logic normal_negative;
    modport source(output valid, hit_found, hit_index, hit_distance, hit_x, hit_y, hit_z,
                   normal_axis, normal_negative, input ready);
    modport sink(input valid, hit_found, hit_index, hit_distance, hit_x, hit_y, hit_z,
                 normal_axis, normal_negative, output ready);
endinterface
`default_nettype wire

>>> rtl/rbc_front.sv
// Front end: accept box words and tag them with their stream position.
`default_nettype none
module rbc_front #(
    parameter int MAX_BOXES = 65536
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    rbc_box_if.sink            box_in,
    output rbc_pkg::item_t     q_item,
    output logic               q_valid,
    input  wire logic          q_ready
);
    localparam int CW = $clog2(MAX_BOXES);

    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic [31:0]   cnt_wide;

    assign box_in.ready = q_ready;
    assign q_valid = box_in.valid;
    assign cnt_wide = 32'(cnt_reg);

    always_comb
    begin
        q_item.corner[0] = box_in.box_min_x;
        q_item.corner[1] = box_in.box_min_y;
        q_item.corner[2] = box_in.box_min_z;
        q_item.corner[3] = box_in.box_max_x;
        q_item.corner[4] = box_in.box_max_y;
        q_item.corner[5] = box_in.box_max_z;
        q_item.index = cnt_wide[15:0];
        q_item.enabled = box_in.box_enabled;
        q_item.last = box_in.last_box;
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (box_in.valid && q_ready)
        begin
            if (box_in.last_box || cnt_reg == CW'(MAX_BOXES - 1))
                cnt_next = '0;
            else
                cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end
endmodule
`default_nettype wire

>>> rtl/rbc_queue.sv
// Two-entry queue between front end and back end.
`default_nettype none
module rbc_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire rbc_pkg::item_t  in_item,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output rbc_pkg::item_t       out_item
);
    rbc_pkg::item_t mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_item = mem_reg[rd_ptr_reg];
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end
endmodule
`default_nettype wire

>>> rtl/rbc_div.sv
// Bit-serial slab divider with saturation and zero-divisor handling.
`default_nettype none
module rbc_div #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [32:0] num,
    input  wire logic signed [31:0] dsor,
    input  wire logic               lower,
    output logic                    done,
    output logic signed [31:0]      quo
);
    localparam int NW = 33 + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [NW-1:0] n_reg;
    logic [NW-1:0] q_reg;
    logic [31:0]   d_reg;
    logic [31:0]   rem_reg;
    logic          neg_reg;
    logic signed [31:0] res_reg;
    logic [32:0]   trial;
    logic          fit;
    logic [32:0]   num_mag;
    logic [31:0]   d_mag;
    logic [31:0]   q_low;
    logic signed [31:0] sat_res;

    assign done = done_reg;
    assign quo = res_reg;
    assign trial = {rem_reg, n_reg[NW-1]};
    assign fit = (trial >= {1'b0, d_reg});
    assign num_mag = num[32] ? 33'(-num) : 33'(num);
    assign d_mag = dsor[31] ? 32'(-dsor) : 32'(dsor);
    assign q_low = q_reg[31:0];

    always_comb
    begin
        if (!neg_reg)
            sat_res = (|q_reg[NW-1:31]) ? rbc_pkg::T_MAX : $signed(q_low);
        else if ((|q_reg[NW-1:32]) || (q_reg[31] && (|q_reg[30:0])))
            sat_res = rbc_pkg::T_MIN;
        else
            sat_res = $signed(32'(-q_low));
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg <= {num_mag, {FRAC_BITS{1'b0}}};
            d_reg <= d_mag;
            rem_reg <= '0;
            q_reg <= '0;
            neg_reg <= num[32] ^ dsor[31];
            if (dsor == 32'sd0)
            begin
                if (num > 33'sd0)
                    res_reg <= rbc_pkg::T_MAX;
                else if (num < 33'sd0)
                    res_reg <= rbc_pkg::T_MIN;
                else
                    res_reg <= lower ? rbc_pkg::T_MIN : rbc_pkg::T_MAX;
            end
        end
        else if (busy_reg)
        begin
            if (cnt_reg == CW'(NW))
                res_reg <= sat_res;
            else
            begin
                rem_reg <= fit ? 32'(trial - {1'b0, d_reg}) : trial[31:0];
                q_reg <= {q_reg[NW-2:0], fit};
                n_reg <= {n_reg[NW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= '0;
                busy_reg <= (dsor != 32'sd0);
                done_reg <= (dsor == 32'sd0);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CW'(NW))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                    cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

>>> rtl/rbc_mul.sv
// Shift-add unsigned multiplier, one multiplier bit per cycle.
`default_nettype none
module rbc_mul (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [rbc_pkg::MUL_W-1:0]       a,
    input  wire logic [rbc_pkg::MUL_W-1:0]       b,
    output logic                                 done,
    output logic [2*rbc_pkg::MUL_W-1:0]          prod
);
    localparam int MW = rbc_pkg::MUL_W;
    localparam int CW = $clog2(MW);

    logic            busy_reg;
    logic            done_reg;
    logic [CW-1:0]   cnt_reg;
    logic [2*MW-1:0] acc_reg;
    logic [2*MW-1:0] mc_reg;
    logic [MW-1:0]   mp_reg;

    assign done = done_reg;
    assign prod = acc_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            mc_reg <= (2*MW)'(a);
            mp_reg <= b;
        end
        else if (busy_reg)
        begin
            if (mp_reg[0])
                acc_reg <= acc_reg + mc_reg;
            mc_reg <= {mc_reg[2*MW-2:0], 1'b0};
            mp_reg <= {1'b0, mp_reg[MW-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CW'(MW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                    cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

>>> rtl/rbc_back.sv
// Back end: slab test, closest tracking, hit point and face normal, result register.
`default_nettype none
module rbc_back #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [rbc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [rbc_pkg::CFG_W-1:0]       cfg_data,
    input  wire logic                            q_valid,
    output logic                                 q_ready,
    input  wire rbc_pkg::item_t                  q_item,
    rbc_hit_if.source                            hit_out
);
    localparam int MW = rbc_pkg::MUL_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_TEST = 3'd2;
    localparam logic [2:0] S_POST = 3'd3;
    localparam logic [2:0] S_PMUL = 3'd4;
    localparam logic [2:0] S_R    = 3'd5;
    localparam logic [2:0] S_CMP  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0] state_reg;
    logic signed [31:0] origin_reg [3];
    logic signed [31:0] dir_reg [3];
    logic [30:0] maxd_reg;

    rbc_pkg::item_t item_reg;
    logic [2:0] k_reg;
    logic [1:0] j_reg;
    logic [2:0] c_reg;
    logic signed [31:0] t_reg [6];
    logic [30:0] closest_reg;
    logic hit_reg;
    logic open_reg;
    logic [15:0] best_idx_reg;
    logic signed [31:0] best_reg [6];
    logic signed [31:0] p_reg [3];
    logic signed [33:0] r_reg [3];
    logic [2*MW-1:0] tmp_reg;
    logic [2:0] g_reg;
    logic div_start_reg;
    logic mul_start_reg;

    logic out_valid_reg;
    logic out_found_reg;
    logic [15:0] out_index_reg;
    logic [30:0] out_dist_reg;
    logic signed [31:0] out_p_reg [3];
    logic [1:0] out_axis_reg;
    logic out_neg_reg;

    logic [1:0] div_axis;
    logic [2:0] div_corner;
    logic signed [32:0] div_num;
    logic div_done;
    logic signed [31:0] div_quo;

    logic [MW-1:0] mul_a;
    logic [MW-1:0] mul_b;
    logic mul_done;
    logic [2*MW-1:0] mul_prod;

    logic [MW-1:0] ar [3];
    logic [MW-1:0] ex [3];
    logic signed [33:0] r_calc [3];

    logic signed [31:0] lo [3];
    logic signed [31:0] hi [3];
    logic signed [31:0] tmin1;
    logic signed [31:0] tmax1;
    logic signed [31:0] tmin2;
    logic box_hit;

    logic signed [63:0] hp_prod;
    logic signed [63:0] hp_sum;
    logic signed [31:0] hp_sat;

    logic [1:0] axis_sel;
    logic out_load;

    assign q_ready = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || hit_out.ready);

    assign hit_out.valid = out_valid_reg;
    assign hit_out.hit_found = out_found_reg;
    assign hit_out.hit_index = out_index_reg;
    assign hit_out.hit_distance = out_dist_reg;
    assign hit_out.hit_x = out_p_reg[0];
    assign hit_out.hit_y = out_p_reg[1];
    assign hit_out.hit_z = out_p_reg[2];
    assign hit_out.normal_axis = out_axis_reg;
    assign hit_out.normal_negative = out_neg_reg;

    assign div_axis = k_reg[2:1];
    assign div_corner = k_reg[0] ? 3'(div_axis) + 3'd3 : 3'(div_axis);
    assign div_num = 33'(signed'(item_reg.corner[div_corner])) - 33'(origin_reg[div_axis]);

    rbc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start_reg), .num(div_num),
        .dsor(dir_reg[div_axis]), .lower(!k_reg[0]), .done(div_done), .quo(div_quo)
    );

    rbc_mul u_mul (
        .clk(clk), .rst_n(rst_n), .start(mul_start_reg), .a(mul_a), .b(mul_b),
        .done(mul_done), .prod(mul_prod)
    );

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            r_calc[a] = {p_reg[a][31], p_reg[a], 1'b0}
                        - (34'(best_reg[a]) + 34'(best_reg[a+3]));
            ar[a] = r_reg[a][33] ? MW'(-r_reg[a]) : MW'(r_reg[a]);
            ex[a] = 34'(best_reg[a+3]) - 34'(best_reg[a]);
            if (ex[a][33])
                ex[a] = MW'(-ex[a]);
            lo[a] = (t_reg[2*a] < t_reg[2*a+1]) ? t_reg[2*a] : t_reg[2*a+1];
            hi[a] = (t_reg[2*a] < t_reg[2*a+1]) ? t_reg[2*a+1] : t_reg[2*a];
        end
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_PMUL || state_reg == S_POST)
        begin
            mul_a = dir_reg[j_reg][31] ? MW'(unsigned'(32'(-dir_reg[j_reg])))
                                       : MW'(unsigned'(32'(dir_reg[j_reg])));
            mul_b = MW'(closest_reg);
        end
        else
        begin
            case (c_reg)
                3'd0: begin mul_a = ar[0]; mul_b = ex[1]; end
                3'd1: begin mul_a = ar[1]; mul_b = ex[0]; end
                3'd2: begin mul_a = ar[0]; mul_b = ex[2]; end
                3'd3: begin mul_a = ar[2]; mul_b = ex[0]; end
                3'd4: begin mul_a = ar[1]; mul_b = ex[2]; end
                3'd5: begin mul_a = ar[2]; mul_b = ex[1]; end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
    end

    always_comb
    begin
        tmin1 = (lo[1] > lo[0]) ? lo[1] : lo[0];
        tmax1 = (hi[1] < hi[0]) ? hi[1] : hi[0];
        tmin2 = (lo[2] > tmin1) ? lo[2] : tmin1;
        box_hit = !(lo[0] > hi[1] || lo[1] > hi[0])
                  && !(tmin1 > hi[2] || lo[2] > tmax1)
                  && (tmin2 > 32'sd0) && (tmin2 < $signed({1'b0, closest_reg}));
    end

    always_comb
    begin
        hp_prod = dir_reg[j_reg][31] ? -$signed(mul_prod[63:0]) : $signed(mul_prod[63:0]);
        hp_sum = 64'(origin_reg[j_reg]) + (hp_prod >>> FRAC_BITS);
        if (hp_sum > 64'(rbc_pkg::T_MAX))
            hp_sat = rbc_pkg::T_MAX;
        else if (hp_sum < 64'(rbc_pkg::T_MIN))
            hp_sat = rbc_pkg::T_MIN;
        else
            hp_sat = hp_sum[31:0];
    end

    always_comb
    begin
        if (g_reg[0] && g_reg[1])
            axis_sel = rbc_pkg::AXIS_X;
        else if (g_reg[2])
            axis_sel = rbc_pkg::AXIS_Y;
        else
            axis_sel = rbc_pkg::AXIS_Z;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && q_valid)
            item_reg <= q_item;
        if (state_reg == S_DIV && div_done)
            t_reg[k_reg] <= div_quo;
        if (state_reg == S_TEST && box_hit)
        begin
            best_idx_reg <= item_reg.index;
            for (int i = 0; i < 6; i++)
                best_reg[i] <= item_reg.corner[i];
        end
        if (state_reg == S_PMUL && mul_done)
            p_reg[j_reg] <= hp_sat;
        if (state_reg == S_R)
        begin
            for (int a = 0; a < 3; a++)
                r_reg[a] <= r_calc[a];
        end
        if (state_reg == S_CMP && mul_done)
        begin
            if (!c_reg[0])
                tmp_reg <= mul_prod;
            else
                g_reg[c_reg[2:1]] <= (tmp_reg > mul_prod);
        end
        if (out_load)
        begin
            out_found_reg <= hit_reg;
            out_index_reg <= hit_reg ? best_idx_reg : 16'd0;
            out_dist_reg <= hit_reg ? closest_reg : 31'd0;
            for (int a = 0; a < 3; a++)
                out_p_reg[a] <= hit_reg ? p_reg[a] : 32'sd0;
            out_axis_reg <= hit_reg ? axis_sel : rbc_pkg::AXIS_X;
            out_neg_reg <= hit_reg ? !(r_reg[axis_sel] > 34'sd0) : 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            origin_reg[0] <= '0;
            origin_reg[1] <= '0;
            origin_reg[2] <= '0;
            dir_reg[0] <= rbc_pkg::DIR_X_RESET;
            dir_reg[1] <= '0;
            dir_reg[2] <= '0;
            maxd_reg <= rbc_pkg::MAX_DIST_RESET;
            closest_reg <= rbc_pkg::MAX_DIST_RESET;
            hit_reg <= 1'b0;
            open_reg <= 1'b0;
            k_reg <= '0;
            j_reg <= '0;
            c_reg <= '0;
            div_start_reg <= 1'b0;
            mul_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            mul_start_reg <= 1'b0;
            if (out_valid_reg && hit_out.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        open_reg <= 1'b1;
                        k_reg <= '0;
                        if (q_item.enabled)
                        begin
                            div_start_reg <= 1'b1;
                            state_reg <= S_DIV;
                        end
                        else
                            state_reg <= S_POST;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        if (k_reg == 3'd5)
                            state_reg <= S_TEST;
                        else
                        begin
                            k_reg <= k_reg + 3'd1;
                            div_start_reg <= 1'b1;
                        end
                    end
                end
                S_TEST:
                begin
                    if (box_hit)
                    begin
                        closest_reg <= 31'(tmin2);
                        hit_reg <= 1'b1;
                    end
                    state_reg <= S_POST;
                end
                S_POST:
                begin
                    if (!item_reg.last)
                        state_reg <= S_IDLE;
                    else if (hit_reg)
                    begin
                        j_reg <= '0;
                        mul_start_reg <= 1'b1;
                        state_reg <= S_PMUL;
                    end
                    else
                        state_reg <= S_OUT;
                end
                S_PMUL:
                begin
                    if (mul_done)
                    begin
                        if (j_reg == 2'd2)
                            state_reg <= S_R;
                        else
                        begin
                            j_reg <= j_reg + 2'd1;
                            mul_start_reg <= 1'b1;
                        end
                    end
                end
                S_R:
                begin
                    c_reg <= '0;
                    mul_start_reg <= 1'b1;
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (mul_done)
                    begin
                        if (c_reg == 3'd5)
                            state_reg <= S_OUT;
                        else
                        begin
                            c_reg <= c_reg + 3'd1;
                            mul_start_reg <= 1'b1;
                        end
                    end
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        out_valid_reg <= 1'b1;
                        closest_reg <= maxd_reg;
                        hit_reg <= 1'b0;
                        open_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
            if (cfg_we)
            begin
                case (cfg_index)
                    rbc_pkg::REG_ORIGIN_X: origin_reg[0] <= $signed(cfg_data);
                    rbc_pkg::REG_ORIGIN_Y: origin_reg[1] <= $signed(cfg_data);
                    rbc_pkg::REG_ORIGIN_Z: origin_reg[2] <= $signed(cfg_data);
                    rbc_pkg::REG_DIR_X: dir_reg[0] <= $signed(cfg_data);
                    rbc_pkg::REG_DIR_Y: dir_reg[1] <= $signed(cfg_data);
                    rbc_pkg::REG_DIR_Z: dir_reg[2] <= $signed(cfg_data);
                    rbc_pkg::REG_MAX_DIST:
                    begin
                        maxd_reg <= cfg_data[30:0];
                        if (!open_reg)
                            closest_reg <= cfg_data[30:0];
                    end
                    default: ;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

>>> rtl/ray_box_closest_hit_top.sv
// Top level of the ray/box closest hit block.
// Usage:
//   Load the ray (origin, direction, max distance) through cfg_we/cfg_index/cfg_data
//   while the block is idle. Then stream boxes on box_in (valid/ready); the word with
//   last_box set closes the query and one result word appears on hit_out.
//   A front end tags each box with its stream position and pushes it into a
//   two-entry queue; the back end pops one box at a time.
// Processing:
//   Enabled box: six serial slab divisions (the divider skips its loop for a zero
//   direction component), then the slab test against the closest hit so far.
//   Disabled box: no divisions and no slab test.
//   Last box: on a miss the back end goes straight to the result register; on a hit
//   nine serial shift-add products (hit point and normal ratios) come first.
//   One box is in the back end at a time, and up to two more wait in the queue.
// Reset: the control state clears, the ray returns to origin 0, direction +x, full range.
// Stall: the result stays on hit_out until taken; the back end holds before
//   loading the next result, and the queue then fills and drops box_in.ready.
`default_nettype none
module ray_box_closest_hit_top #(
    parameter int MAX_BOXES = 65536,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [rbc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [rbc_pkg::CFG_W-1:0]       cfg_data,
    rbc_box_if.sink                              box_in,
    rbc_hit_if.source                            hit_out
);
    rbc_pkg::item_t f_item;
    rbc_pkg::item_t b_item;
    logic f_valid;
    logic f_ready;
    logic b_valid;
    logic b_ready;

    rbc_front #(.MAX_BOXES(MAX_BOXES)) u_front (
        .clk(clk), .rst_n(rst_n), .box_in(box_in),
        .q_item(f_item), .q_valid(f_valid), .q_ready(f_ready)
    );

    rbc_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
        .out_valid(b_valid), .out_ready(b_ready), .out_item(b_item)
    );

    rbc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .q_valid(b_valid), .q_ready(b_ready), .q_item(b_item), .hit_out(hit_out)
    );

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        hit_out.valid && !hit_out.hit_found |->
            hit_out.hit_distance == 31'd0 && hit_out.hit_index == 16'd0)
        else $error("miss result carries nonzero fields");

    a_hit_dist: assert property (@(posedge clk) disable iff (!rst_n)
        hit_out.valid && hit_out.hit_found |-> hit_out.hit_distance != 31'd0)
        else $error("hit with zero distance");

    a_axis: assert property (@(posedge clk) disable iff (!rst_n)
        hit_out.valid |-> hit_out.normal_axis != 2'd3)
        else $error("invalid normal axis");
endmodule
`default_nettype wire
